### hdl/sks_pkg.sv
// Package for the sorted key set table.
// Field widths, operation and status codes, defaults and the cell control struct.
// No dependencies.
`default_nettype none

package sks_pkg;

    localparam int OP_W          = 2;
    localparam int KEY_IN_W      = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic search;      // compare entries with the incoming key
        logic shift_up;    // open a gap at the key's slot
        logic shift_down;  // close the gap at the key's slot
    } sks_ctl_t;

endpackage

`default_nettype wire

### hdl/sks_if.sv
// Channel interfaces of the sorted key set table: request and response.
// Depends on sks_pkg.
`default_nettype none

interface sks_req_if
    import sks_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface sks_rsp_if
    import sks_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output hit, output status, output count, input ready);
    modport sink   (input valid, input hit, input status, input count, output ready);
endinterface

`default_nettype wire

### hdl/sks_cell.sv
// One slot of the sorted row: holds an entry and its compare flags.
// Takes a neighbor's entry or the key when the row shifts. Depends on sks_pkg.
`default_nettype none

module sks_cell
    import sks_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sks_ctl_t             ctl,
    input  wire logic [KEY_WIDTH-1:0] key,
    input  wire logic                 occupied,
    input  wire logic                 left_lt,
    input  wire logic [KEY_WIDTH-1:0] left_entry,
    input  wire logic [KEY_WIDTH-1:0] right_entry,
    output logic [KEY_WIDTH-1:0]      entry,
    output logic                      lt,
    output logic                      eq
);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic                 lt_reg;
    logic                 eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctl.search)
        begin
            lt_reg <= occupied && (entry_reg < key);
            eq_reg <= occupied && (entry_reg == key);
        end
    end

    // Slots below the key's position keep their entry; the rest move.
    always_ff @(posedge clk)
    begin
        if (ctl.shift_up && !lt_reg)
        begin
            entry_reg <= left_lt ? key : left_entry;
        end
        else if (ctl.shift_down && !lt_reg)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

### hdl/sorted_key_set_table.sv
// Top level of the sorted key set table: handshake, control and the row of cells.
// Depends on sks_pkg, sks_if and sks_cell.
//
// Holds up to CAPACITY distinct keys in ascending order in a row of cells. Each
// request inserts, removes or queries one key and gives one response with hit,
// status and the count after the operation. In S_IDLE, at the edge a request beat
// is taken, every cell compares its entry with the key in parallel. In S_APPLY
// the cells at and above the key's slot shift up or down by one place and the
// response is registered; no new request is taken before that, and S_APPLY
// waits while an earlier response is still unread. Operation code 3 acts as a
// query. Keys are cut or zero-padded to KEY_WIDTH bits.
`default_nettype none

module sorted_key_set_table
    import sks_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sks_req_if.sink   req,
    sks_rsp_if.source rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic                 rsp_valid_reg;
    logic                 hit_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    logic [KEY_WIDTH-1:0] key_w;
    logic [KEY_WIDTH-1:0] cell_key;
    logic                 take;
    logic                 go;
    logic                 present;
    logic                 full;
    logic [STATUS_W-1:0]  status_next;
    sks_ctl_t             ctl;

    logic [KEY_WIDTH-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;

    generate
        if (KEY_WIDTH > KEY_IN_W)
        begin : g_key_ext
            assign key_w = {{(KEY_WIDTH - KEY_IN_W){1'b0}}, req.key};
        end
        else if (KEY_WIDTH == KEY_IN_W)
        begin : g_key_eq
            assign key_w = req.key;
        end
        else
        begin : g_key_cut
            assign key_w = req.key[KEY_WIDTH-1:0];
        end

        if (OCC_W >= COUNT_W)
        begin : g_cnt_cut
            assign count_next = occ_next[COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign count_next = {{(COUNT_W - OCC_W){1'b0}}, occ_next};
        end
    endgenerate

    assign take    = req.valid && (state_reg == S_IDLE);
    assign go      = (state_reg == S_APPLY) && (!rsp_valid_reg || rsp.ready);
    assign present = |eq_vec;
    assign full    = (occ_reg == OCC_W'(CAPACITY));
    // Compare runs on the incoming key, the shift on the stored one.
    assign cell_key = take ? key_w : key_reg;

    always_comb
    begin
        ctl         = '0;
        ctl.search  = take;
        occ_next    = occ_reg;
        status_next = ST_DONE;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (present)
                begin
                    status_next = ST_NO_CHANGE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.shift_up = go;
                    occ_next     = occ_reg + OCC_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!present)
                begin
                    status_next = ST_NO_CHANGE;
                end
                else
                begin
                    ctl.shift_down = go;
                    occ_next       = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            op_reg        <= OP_QUERY;
            key_reg       <= '0;
            hit_reg       <= 1'b0;
            status_reg    <= ST_DONE;
            count_reg     <= '0;
        end
        else
        begin
            // a new response in the same cycle keeps valid high
            if (rsp_valid_reg && rsp.ready && !go)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        op_reg    <= req.operation;
                        key_reg   <= key_w;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (go)
                    begin
                        occ_reg       <= occ_next;
                        rsp_valid_reg <= 1'b1;
                        hit_reg       <= present;
                        status_reg    <= status_next;
                        count_reg     <= count_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.hit    = hit_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = count_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                 left_lt;
            logic [KEY_WIDTH-1:0] left_entry;
            logic [KEY_WIDTH-1:0] right_entry;
            logic                 occupied;

            assign occupied = (OCC_W'(i) < occ_reg);

            if (i == 0)
            begin : g_first
                assign left_lt    = 1'b1;
                assign left_entry = cell_key;
            end
            else
            begin : g_mid
                assign left_lt    = lt_vec[i-1];
                assign left_entry = entry_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_entry = entry_w[i];
            end
            else
            begin : g_inner
                assign right_entry = entry_w[i+1];
            end

            sks_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (cell_key),
                .occupied    (occupied),
                .left_lt     (left_lt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_w[i]),
                .lt          (lt_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

endmodule

`default_nettype wire
